@@ hw/rtl/edfs_pkg.sv @@
package edfs_pkg;

  localparam int TASK_SLOTS_DEF = 16;
  // Widest slot index over the supported range of slot counts
  localparam int ID_FW = 6;
  localparam int TID_SPAN = 16;
  localparam logic [30:0] MAX31 = 31'h7FFF_FFFF;

  localparam logic [3:0] OP_TICK   = 4'd0;
  localparam logic [3:0] OP_CREATE = 4'd1;
  localparam logic [3:0] OP_EXIT   = 4'd2;
  localparam logic [3:0] OP_YIELD  = 4'd3;
  localparam logic [3:0] OP_SLEEP  = 4'd4;
  localparam logic [3:0] OP_PYIELD = 4'd5;
  localparam logic [3:0] OP_SETDL  = 4'd6;
  localparam logic [3:0] OP_SCHED  = 4'd7;
  localparam logic [3:0] OP_START  = 4'd8;
  localparam logic [3:0] OP_INFO   = 4'd9;

  localparam logic [1:0] ST_DORMANT  = 2'd0;
  localparam logic [1:0] ST_READY    = 2'd1;
  localparam logic [1:0] ST_RUNNING  = 2'd2;
  localparam logic [1:0] ST_SLEEPING = 2'd3;

  localparam logic [1:0] PRE_NONE  = 2'd0;
  localparam logic [1:0] PRE_TICK  = 2'd1;
  localparam logic [1:0] PRE_SCHED = 2'd2;
  localparam logic [1:0] PRE_START = 2'd3;

  localparam logic [2:0] ACT_CREATE = 3'd0;
  localparam logic [2:0] ACT_EXIT   = 3'd1;
  localparam logic [2:0] ACT_YIELD  = 3'd2;
  localparam logic [2:0] ACT_SLEEP  = 3'd3;
  localparam logic [2:0] ACT_PYIELD = 3'd4;
  localparam logic [2:0] ACT_SETDL  = 3'd5;
  localparam logic [2:0] ACT_RUN    = 3'd6;

  typedef struct packed {
    logic             pre_en;
    logic [1:0]       pre_act;
    logic             post_en;
    logic [2:0]       post_act;
    logic [ID_FW-1:0] post_id;
    logic [ID_FW-1:0] run_id;
    logic [3:0]       tid;
    logic [30:0]      tv;
  } cmd_t;

  typedef struct packed {
    logic             best_v;
    logic [ID_FW-1:0] best_id;
    logic [30:0]      best_tl;
    logic             free_v;
    logic [ID_FW-1:0] free_id;
    logic [1:0]       tid_state;
    logic [30:0]      tid_period;
    logic [30:0]      tid_tl;
    logic [1:0]       r_state;
    logic [30:0]      r_tl;
    logic             sw_any;
  } wave_t;

endpackage

@@ hw/rtl/edfs_if.sv @@
interface edfs_req_if;
  logic               valid;
  logic               ready;
  logic [3:0]         opcode;
  logic [3:0]         task_id;
  logic signed [31:0] time_value;
  modport source (output valid, opcode, task_id, time_value, input ready);
  modport sink (input valid, opcode, task_id, time_value, output ready);
endinterface

interface edfs_rsp_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [3:0]  result_task;
  logic        switch_request;
  logic [1:0]  info_state;
  logic [30:0] info_deadline;
  logic [30:0] info_remaining;
  modport source (output valid, status, result_task, switch_request, info_state,
                  info_deadline, info_remaining, input ready);
  modport sink (input valid, status, result_task, switch_request, info_state,
                info_deadline, info_remaining, output ready);
endinterface

@@ hw/rtl/edfs_cell.sv @@
module edfs_cell #(
  parameter int TASK_SLOTS = 16,
  parameter int INDEX = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  edfs_pkg::cmd_t  cmd,
  input  logic          wave_valid_in,
  input  edfs_pkg::wave_t wave_in,
  output logic          wave_valid,
  output edfs_pkg::wave_t wave
);
  import edfs_pkg::*;

  localparam bit IS_USER = (INDEX != 0);

  logic [1:0]  state;
  logic [30:0] period;
  logic [30:0] tl;
  logic [30:0] sleep_left;
  logic        flag;
  logic [30:0] tl_dec;
  logic [30:0] sl_dec;
  logic        me_r;
  logic        me_post;
  logic        hit_tid;
  wave_t       wave_next;

  assign tl_dec  = (tl != 31'd0) ? tl - 31'd1 : tl;
  assign sl_dec  = (sleep_left != 31'd0) ? sleep_left - 31'd1 : sleep_left;
  assign me_r    = (cmd.run_id == ID_FW'(INDEX));
  assign me_post = (cmd.post_id == ID_FW'(INDEX));
  assign hit_tid = (INDEX < TID_SPAN) && (cmd.tid == 4'(INDEX));

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IS_USER ? ST_DORMANT : ST_READY;
      period     <= IS_USER ? 31'd0 : MAX31;
      tl         <= IS_USER ? 31'd0 : MAX31;
      sleep_left <= 31'd0;
      flag       <= 1'b0;
      wave_valid <= 1'b0;
    end else begin
      wave_valid <= wave_valid_in;
      if (cmd.pre_en) begin
        flag <= 1'b0;
        case (cmd.pre_act)
          PRE_TICK: begin
            if (IS_USER) begin
              if (state == ST_SLEEPING) begin
                sleep_left <= sl_dec;
                if (sl_dec == 31'd0) begin
                  tl    <= period;
                  state <= ST_READY;
                  flag  <= 1'b1;
                end
              end else if (state == ST_READY || state == ST_RUNNING) begin
                tl <= tl_dec;
                // reload an expired running task
                if (me_r && state == ST_RUNNING && tl_dec == 31'd0) begin
                  tl   <= period;
                  flag <= 1'b1;
                end
              end
            end
          end
          PRE_SCHED: begin
            if (me_r) begin
              if (state == ST_RUNNING) begin
                state <= ST_READY;
              end else if (state == ST_DORMANT && IS_USER) begin
                period     <= 31'd0;
                tl         <= 31'd0;
                sleep_left <= 31'd0;
              end
            end
          end
          PRE_START: begin
            if (IS_USER && state == ST_READY) tl <= period;
          end
          default: ;
        endcase
      end
      if (cmd.post_en && me_post) begin
        case (cmd.post_act)
          ACT_CREATE: begin
            state      <= ST_READY;
            period     <= cmd.tv;
            tl         <= cmd.tv;
            sleep_left <= 31'd0;
          end
          ACT_EXIT:  state <= ST_DORMANT;
          ACT_YIELD: tl <= period;
          ACT_SLEEP: begin
            sleep_left <= cmd.tv;
            state      <= ST_SLEEPING;
          end
          ACT_PYIELD: begin
            sleep_left <= (tl != 31'd0) ? tl : period;
            state      <= ST_SLEEPING;
          end
          ACT_SETDL: begin
            period <= cmd.tv;
            tl     <= cmd.tv;
          end
          ACT_RUN: begin
            if (tl == 31'd0) tl <= period;
            state <= ST_RUNNING;
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    wave_next = wave_in;
    // incoming candidate always has a lower id, so only a strictly smaller time wins
    if (IS_USER && state == ST_READY && (!wave_in.best_v || tl < wave_in.best_tl)) begin
      wave_next.best_v  = 1'b1;
      wave_next.best_id = ID_FW'(INDEX);
      wave_next.best_tl = tl;
    end
    if (IS_USER && state == ST_DORMANT && !wave_in.free_v) begin
      wave_next.free_v  = 1'b1;
      wave_next.free_id = ID_FW'(INDEX);
    end
    if (hit_tid) begin
      wave_next.tid_state  = state;
      wave_next.tid_period = period;
      wave_next.tid_tl     = tl;
    end
    if (me_r) begin
      wave_next.r_state = state;
      wave_next.r_tl    = tl;
    end
    wave_next.sw_any = wave_in.sw_any | flag;
  end

  always_ff @(posedge clk) begin
    if (wave_valid_in) wave <= wave_next;
  end

endmodule

@@ hw/rtl/edf_task_scheduler_unit.sv @@
// channel | dir | beat contents
// req     | in  | opcode, task_id, time_value
// rsp     | out | status, result_task, switch_request, info_state/deadline/remaining
//
// Each request passes from accept to result through one broadcast update step, a scan
// (launch, then one slot cell per cycle), and one commit step. The next request is
// accepted in the cycle after the commit.
// rst is synchronous: slot 0 (idle) ready, all other slots dormant, scheduler not started.
// A result held by a stalled rsp keeps the commit cycle waiting; req is taken meanwhile only in idle.
module edf_task_scheduler_unit #(
  parameter int TASK_SLOTS = edfs_pkg::TASK_SLOTS_DEF
) (
  input logic clk,
  input logic rst,
  edfs_req_if.sink   req,
  edfs_rsp_if.source rsp
);
  import edfs_pkg::*;

  localparam int IdW = $clog2(TASK_SLOTS);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PRE  = 2'd1;
  localparam logic [1:0] S_WAVE = 2'd2;
  localparam logic [1:0] S_POST = 2'd3;

  logic [1:0]     state;
  logic [3:0]     op;
  logic [3:0]     tid;
  logic [31:0]    tv;
  logic [IdW-1:0] running_id;
  logic           has_current;
  logic           started;
  logic [4:0]     live_count;
  logic           launch;

  logic [IdW-1:0] running_id_next;
  logic           has_current_next;
  logic           started_next;
  logic [4:0]     live_count_next;

  cmd_t  cmd;
  wave_t w;
  logic  wave_v [TASK_SLOTS];
  wave_t wave_d [TASK_SLOTS];

  logic        commit;
  logic        tv_pos;
  logic        cur;
  logic        cur_user_run;
  logic        status_c;
  logic        sw_c;
  logic        res_set;
  logic [IdW-1:0] res_c;
  logic [1:0]  i_state;
  logic [30:0] i_dl;
  logic [30:0] i_rem;
  logic [IdW-1:0] best_id;
  logic [IdW-1:0] free_id;
  logic [IdW-1:0] sel;
  logic        best_outr;
  logic        free_outr;
  logic        tid_outr;
  logic [IdW-1:0] res_final;

  logic        out_valid;
  logic        out_status;
  logic [3:0]  out_task;
  logic        out_sw;
  logic [1:0]  out_istate;
  logic [30:0] out_idl;
  logic [30:0] out_irem;

  assign req.ready = (state == S_IDLE);
  assign commit    = (state == S_POST) && (!out_valid || rsp.ready);
  assign w         = wave_d[TASK_SLOTS-1];

  assign tv_pos  = (tv != 32'd0) && !tv[31];
  assign cur     = started && has_current;
  assign cur_user_run = cur && (running_id != '0) && (w.r_state == ST_RUNNING);
  assign best_id = w.best_id[IdW-1:0];
  assign free_id = w.free_id[IdW-1:0];
  assign sel     = w.best_v ? best_id : '0;

  assign best_outr = (running_id == '0) || (w.best_tl < w.r_tl) ||
                     (w.best_tl == w.r_tl && best_id < running_id);
  // a new task landing in the slot of the current one never outranks itself
  assign free_outr = (free_id != running_id) &&
                     ((running_id == '0) || (tv[30:0] < w.r_tl) ||
                      (tv[30:0] == w.r_tl && free_id < running_id));
  assign tid_outr  = (running_id == '0) || (tv[30:0] < w.r_tl) ||
                     (tv[30:0] == w.r_tl && ID_FW'(tid) < ID_FW'(running_id));

  always_comb begin
    cmd          = '0;
    cmd.pre_en   = (state == S_PRE);
    cmd.pre_act  = PRE_NONE;
    cmd.run_id   = ID_FW'(running_id);
    cmd.tid      = tid;
    cmd.tv       = tv[30:0];
    case (op)
      OP_TICK:  if (cur) cmd.pre_act = PRE_TICK;
      OP_SCHED: if (has_current) cmd.pre_act = PRE_SCHED;
      OP_START: if (!started) cmd.pre_act = PRE_START;
      default:  cmd.pre_act = PRE_NONE;
    endcase

    status_c         = 1'b0;
    sw_c             = 1'b0;
    res_set          = 1'b0;
    res_c            = '0;
    i_state          = ST_DORMANT;
    i_dl             = 31'd0;
    i_rem            = 31'd0;
    running_id_next  = running_id;
    has_current_next = has_current;
    started_next     = started;
    live_count_next  = live_count;
    cmd.post_act     = ACT_EXIT;
    cmd.post_id      = ID_FW'(running_id);
    unique case (op)
      OP_TICK: begin
        if (cur) sw_c = w.sw_any | (w.best_v && best_outr);
      end
      OP_CREATE: begin
        if (!tv_pos || !w.free_v) begin
          status_c = 1'b1;
        end else begin
          cmd.post_en  = commit;
          cmd.post_act = ACT_CREATE;
          cmd.post_id  = ID_FW'(free_id);
          if (live_count < 5'd31) live_count_next = live_count + 5'd1;
          sw_c    = cur && free_outr;
          res_set = 1'b1;
          res_c   = free_id;
        end
      end
      OP_EXIT: begin
        if (!cur_user_run) begin
          status_c = 1'b1;
        end else begin
          cmd.post_en  = commit;
          cmd.post_act = ACT_EXIT;
          if (live_count > 5'd1) live_count_next = live_count - 5'd1;
          sw_c = 1'b1;
        end
      end
      OP_YIELD: begin
        if (!cur) begin
          status_c = 1'b1;
        end else begin
          cmd.post_en  = commit && (running_id != '0) && (w.r_state == ST_RUNNING);
          cmd.post_act = ACT_YIELD;
          sw_c = 1'b1;
        end
      end
      OP_SLEEP: begin
        if (!cur_user_run) begin
          status_c = 1'b1;
        end else begin
          cmd.post_en  = commit;
          cmd.post_act = tv_pos ? ACT_SLEEP : ACT_YIELD;
          sw_c = 1'b1;
        end
      end
      OP_PYIELD: begin
        if (!cur_user_run) begin
          status_c = 1'b1;
        end else begin
          cmd.post_en  = commit;
          cmd.post_act = ACT_PYIELD;
          sw_c = 1'b1;
        end
      end
      OP_SETDL: begin
        // an out-of-range slot reads back as dormant from the scan
        if (!tv_pos || tid == 4'd0 || w.tid_state != ST_READY ||
            (started && ID_FW'(tid) == ID_FW'(running_id))) begin
          status_c = 1'b1;
        end else begin
          cmd.post_en  = commit;
          cmd.post_act = ACT_SETDL;
          cmd.post_id  = ID_FW'(tid);
          sw_c = cur && tid_outr;
        end
      end
      OP_SCHED: begin
        cmd.post_en      = commit;
        cmd.post_act     = ACT_RUN;
        cmd.post_id      = ID_FW'(sel);
        running_id_next  = sel;
        has_current_next = 1'b1;
        res_set = 1'b1;
        res_c   = sel;
      end
      OP_START: begin
        if (started) begin
          status_c = 1'b1;
        end else begin
          started_next = 1'b1;
          sw_c = 1'b1;
        end
      end
      OP_INFO: begin
        if (w.tid_state == ST_DORMANT) begin
          status_c = 1'b1;
        end else begin
          i_state = w.tid_state;
          i_dl    = w.tid_period;
          i_rem   = w.tid_tl;
        end
      end
      default: status_c = 1'b1;
    endcase
  end

  assign res_final = res_set ? res_c :
                     ((started_next && has_current_next) ? running_id_next : '0);

  generate
    for (genvar k = 0; k < TASK_SLOTS; k++) begin : g_cell
      if (k == 0) begin : g_head
        edfs_cell #(.TASK_SLOTS(TASK_SLOTS), .INDEX(k)) u_cell (
          .clk(clk), .rst(rst), .cmd(cmd),
          .wave_valid_in(launch), .wave_in('0),
          .wave_valid(wave_v[k]), .wave(wave_d[k])
        );
      end else begin : g_body
        edfs_cell #(.TASK_SLOTS(TASK_SLOTS), .INDEX(k)) u_cell (
          .clk(clk), .rst(rst), .cmd(cmd),
          .wave_valid_in(wave_v[k-1]), .wave_in(wave_d[k-1]),
          .wave_valid(wave_v[k]), .wave(wave_d[k])
        );
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      running_id  <= '0;
      has_current <= 1'b0;
      started     <= 1'b0;
      live_count  <= 5'd1;
      launch      <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      launch <= (state == S_PRE);
      if (out_valid && rsp.ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (req.valid) state <= S_PRE;
        S_PRE:  state <= S_WAVE;
        S_WAVE: if (wave_v[TASK_SLOTS-1]) state <= S_POST;
        S_POST: begin
          if (commit) begin
            running_id  <= running_id_next;
            has_current <= has_current_next;
            started     <= started_next;
            live_count  <= live_count_next;
            out_valid   <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      op  <= req.opcode;
      tid <= req.task_id;
      tv  <= req.time_value;
    end
    if (commit) begin
      out_status <= status_c;
      out_task   <= 4'(res_final);
      out_sw     <= sw_c;
      out_istate <= i_state;
      out_idl    <= i_dl;
      out_irem   <= i_rem;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.status         = out_status;
  assign rsp.result_task    = out_task;
  assign rsp.switch_request = out_sw;
  assign rsp.info_state     = out_istate;
  assign rsp.info_deadline  = out_idl;
  assign rsp.info_remaining = out_irem;

endmodule

@@ test/sched_monitor.sv @@
module sched_monitor
  import edfs_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  edfs_req_if   req,
  edfs_rsp_if   rsp,
  output int    errors,
  output int    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = TASK_SLOTS_DEF;

  typedef struct packed {
    logic        status;
    logic [3:0]  result_task;
    logic        switch_request;
    logic [1:0]  info_state;
    logic [30:0] info_deadline;
    logic [30:0] info_remaining;
  } rsp_beat_t;

  logic [1:0]  slot_st [SLOTS];
  logic [30:0] period  [SLOTS];
  logic [30:0] left    [SLOTS];
  logic [30:0] nap     [SLOTS];
  logic [3:0]  cur_id;
  logic        cur_valid;
  logic        running;

  rsp_beat_t due_rsp[$];

  function automatic bit beats(input int c, input int inc);
    if (c == 0) return 0;
    if (inc == 0) return 1;
    if (left[c] != left[inc]) return left[c] < left[inc];
    return c < inc;
  endfunction

  function automatic bit user_running();
    return running && cur_valid && cur_id != 0 && slot_st[cur_id] == ST_RUNNING;
  endfunction

  function automatic void clear_tables();
    for (int i = 0; i < SLOTS; i++) begin
      slot_st[i] = ST_DORMANT;
      period[i] = '0;
      left[i] = '0;
      nap[i] = '0;
    end
    slot_st[0] = ST_READY;
    period[0] = MAX31;
    left[0] = MAX31;
    cur_id = '0;
    cur_valid = 0;
    running = 0;
  endfunction

  function automatic rsp_beat_t next_rsp(input logic [3:0] op, input logic [3:0] tid,
                                         input logic signed [31:0] tv);
    rsp_beat_t o;
    bit tv_pos;
    bit res_set;
    int r;
    int slot;
    int sel;
    o = '0;
    tv_pos = tv > 0;
    res_set = 0;
    r = cur_id;
    case (op)
      OP_TICK: begin
        if (running && cur_valid) begin
          for (int i = 1; i < SLOTS; i++) begin
            if (slot_st[i] == ST_SLEEPING) begin
              if (nap[i] > 0) nap[i]--;
              if (nap[i] == 0) begin
                left[i] = period[i];
                slot_st[i] = ST_READY;
                o.switch_request = 1;
              end
            end else if (slot_st[i] == ST_READY || slot_st[i] == ST_RUNNING) begin
              if (left[i] > 0) left[i]--;
            end
          end
          if (r != 0 && slot_st[r] == ST_RUNNING && left[r] == 0) begin
            left[r] = period[r];
            o.switch_request = 1;
          end
          for (int i = 1; i < SLOTS; i++) begin
            if (slot_st[i] == ST_READY && (r == 0 || beats(i, r))) begin
              o.switch_request = 1;
              break;
            end
          end
        end
      end
      OP_CREATE: begin
        slot = 0;
        if (tv_pos) begin
          for (int i = 1; i < SLOTS; i++) begin
            if (slot_st[i] == ST_DORMANT) begin
              slot = i;
              break;
            end
          end
        end
        if (slot == 0) o.status = 1;
        else begin
          slot_st[slot] = ST_READY;
          period[slot] = tv[30:0];
          left[slot] = tv[30:0];
          nap[slot] = '0;
          if (running && cur_valid && beats(slot, r)) o.switch_request = 1;
          o.result_task = slot[3:0];
          res_set = 1;
        end
      end
      OP_EXIT: begin
        if (!user_running()) o.status = 1;
        else begin
          slot_st[r] = ST_DORMANT;
          o.switch_request = 1;
        end
      end
      OP_YIELD: begin
        if (!running || !cur_valid) o.status = 1;
        else begin
          if (r != 0 && slot_st[r] == ST_RUNNING) left[r] = period[r];
          o.switch_request = 1;
        end
      end
      OP_SLEEP: begin
        if (!user_running()) o.status = 1;
        else begin
          if (!tv_pos) left[r] = period[r];
          else begin
            nap[r] = tv[30:0];
            slot_st[r] = ST_SLEEPING;
          end
          o.switch_request = 1;
        end
      end
      OP_PYIELD: begin
        if (!user_running()) o.status = 1;
        else begin
          nap[r] = (left[r] > 0) ? left[r] : period[r];
          slot_st[r] = ST_SLEEPING;
          o.switch_request = 1;
        end
      end
      OP_SETDL: begin
        if (!tv_pos || tid == 0 || slot_st[tid] != ST_READY || (running && tid == r))
          o.status = 1;
        else begin
          period[tid] = tv[30:0];
          left[tid] = tv[30:0];
          if (running && cur_valid && beats(tid, r)) o.switch_request = 1;
        end
      end
      OP_SCHED: begin
        sel = 0;
        if (cur_valid) begin
          if (slot_st[r] == ST_RUNNING) slot_st[r] = ST_READY;
          else if (slot_st[r] == ST_DORMANT && r != 0) begin
            period[r] = '0;
            left[r] = '0;
            nap[r] = '0;
          end
        end
        for (int i = 1; i < SLOTS; i++)
          if (slot_st[i] == ST_READY && (sel == 0 || beats(i, sel))) sel = i;
        if (sel != 0 && left[sel] == 0) left[sel] = period[sel];
        cur_id = sel[3:0];
        cur_valid = 1;
        slot_st[sel] = ST_RUNNING;
        o.result_task = sel[3:0];
        res_set = 1;
      end
      OP_START: begin
        if (running) o.status = 1;
        else begin
          for (int i = 1; i < SLOTS; i++)
            if (slot_st[i] == ST_READY) left[i] = period[i];
          running = 1;
          o.switch_request = 1;
        end
      end
      OP_INFO: begin
        if (slot_st[tid] == ST_DORMANT) o.status = 1;
        else begin
          o.info_state = slot_st[tid];
          o.info_deadline = period[tid];
          o.info_remaining = left[tid];
        end
      end
      default: o.status = 1;
    endcase
    if (!res_set) o.result_task = (running && cur_valid) ? cur_id : 4'd0;
    return o;
  endfunction

  rsp_beat_t got, want;
  assign pending = due_rsp.size();

  always @(posedge clk) begin
    if (rst) begin
      clear_tables();
      due_rsp.delete();
      errors <= 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        got = {rsp.status, rsp.result_task, rsp.switch_request, rsp.info_state,
               rsp.info_deadline, rsp.info_remaining};
        if (due_rsp.size() == 0) begin
          if (errors < 10) $display("%0t: result beat with nothing expected", $realtime);
          errors <= errors + 1;
        end else begin
          want = due_rsp.pop_front();
          if (got != want) begin
            if (errors < 10)
              $display("%0t: mismatch exp st=%0d id=%0d sw=%0d is=%0d dl=%0d rem=%0d",
                       $realtime, want.status, want.result_task, want.switch_request,
                       want.info_state, want.info_deadline, want.info_remaining,
                       "  got st=%0d id=%0d sw=%0d is=%0d dl=%0d rem=%0d",
                       got.status, got.result_task, got.switch_request,
                       got.info_state, got.info_deadline, got.info_remaining);
            errors <= errors + 1;
          end
        end
      end
      if (req.valid && req.ready)
        due_rsp.push_back(next_rsp(req.opcode, req.task_id, req.time_value));
    end
  end
endmodule

@@ test/tb_top.sv @@
module tb_top;
  import edfs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [3:0]  OP_BAD_LO = 4'd10;
  localparam logic [3:0]  OP_BAD_HI = 4'd15;
  localparam logic [31:0] TV_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] TV_MIN = 32'h8000_0000;
  localparam int          SETTLE = TASK_SLOTS_DEF * 3 + 10;

  logic clk;
  logic rst;
  int   errors;
  int   pending;
  bit   no_idle;
  bit   hold_rsp;

  edfs_req_if req();
  edfs_rsp_if rsp();

  edf_task_scheduler_unit DUT (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  sched_monitor mon (.clk(clk), .rst(rst), .req(req), .rsp(rsp),
                     .errors(errors), .pending(pending));

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb_top: errors");
    $finish;
  end

  task automatic put(input logic [3:0] op, input logic [3:0] id, input logic [31:0] v);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      req.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1;
    req.opcode <= op;
    req.task_id <= id;
    req.time_value <= v;
    do @(posedge clk); while (!req.ready);
  endtask

  function automatic logic [31:0] pick_time();
    case ($urandom_range(0, 11))
      0: return $urandom;
      1: return 0;
      2: return -$urandom_range(1, 50);
      3: return TV_MAX;
      4: return TV_MIN;
      default: return $urandom_range(1, 30);
    endcase
  endfunction

  function automatic logic [3:0] pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 22) return OP_TICK;
    if (r < 36) return OP_CREATE;
    if (r < 44) return OP_EXIT;
    if (r < 52) return OP_YIELD;
    if (r < 60) return OP_SLEEP;
    if (r < 66) return OP_PYIELD;
    if (r < 72) return OP_SETDL;
    if (r < 88) return OP_SCHED;
    if (r < 95) return OP_INFO;
    if (r < 97) return OP_START;
    return 4'($urandom_range(OP_BAD_LO, OP_BAD_HI));
  endfunction

  // response side: random stall per beat, one long hold-off on request
  initial begin
    int n;
    rsp.ready <= 0;
    @(negedge rst);
    forever begin
      n = no_idle ? 0 : $urandom_range(0, 19);
      if (hold_rsp) begin
        n = 400;
        hold_rsp = 0;
      end
      if (n > 0) begin
        rsp.ready <= 0;
        repeat (n) @(posedge clk);
      end
      rsp.ready <= 1;
      do @(posedge clk); while (!(rsp.valid && rsp.ready));
    end
  end

  initial begin
    int guard;
    rst <= 1;
    no_idle = 0;
    hold_rsp = 0;
    req.valid <= 0;
    req.opcode <= OP_TICK;
    req.task_id <= '0;
    req.time_value <= '0;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // before start
    put(OP_TICK, 0, 0);
    put(OP_CREATE, 0, 0);
    put(OP_CREATE, 0, TV_MIN);
    put(OP_CREATE, 0, TV_MAX);
    put(OP_CREATE, 0, 3);
    put(OP_INFO, 0, 0);
    put(OP_INFO, 15, 0);
    put(OP_INFO, 1, 0);
    put(OP_SETDL, 1, 5);
    put(OP_SETDL, 0, 5);
    put(OP_EXIT, 0, 0);
    put(OP_YIELD, 0, 0);
    put(OP_SLEEP, 0, 4);
    put(OP_BAD_HI, 4'hF, 32'hFFFF_FFFF);
    put(OP_START, 0, 0);
    put(OP_START, 0, 0);
    // started, nothing current yet
    put(OP_TICK, 0, 0);
    put(OP_YIELD, 0, 0);
    put(OP_SCHED, 0, 0);
    put(OP_TICK, 0, 0);
    put(OP_SLEEP, 0, 0);
    put(OP_SETDL, 2, 7);
    put(OP_PYIELD, 0, 0);
    put(OP_SCHED, 0, 0);
    put(OP_EXIT, 0, 0);

    for (int k = 0; k < 550; k++) begin
      if (k % 100 == 50) no_idle = ~no_idle;
      if (k == 150) hold_rsp = 1;
      if (k == 300) begin
        // let the block drain completely before going on
        req.valid <= 0;
        while (pending != 0) @(posedge clk);
      end
      put(pick_op(), 4'($urandom_range(0, 15)), pick_time());
    end
    req.valid <= 0;

    guard = 0;
    while (pending != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end
endmodule
